### rtl/core/pcfg_pkg.sv
// shared types, widths and constants of the pulse count frame generator
// no dependencies; imported by every module of the block
package pcfg_pkg;

  // field and register widths
  localparam int CODE_W = 8;
  localparam int TEMP_W = 14;
  localparam int DUR_W = 15;
  localparam int SYNC_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = SYNC_W;

  // quantizer divider: dividend magnitude below 2**DIV_BITS
  localparam int DIV_BITS = 9;
  localparam int DIV_CNT_W = 4;

  localparam int FRAME_ITEMS_DEF = 64;

  localparam logic [DUR_W-1:0] FIELD_MAX_US = DUR_W'(32767);
  localparam logic [CODE_W-1:0] DEFAULT_STEP = CODE_W'(5);

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] REG_OFF_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW = 3'd6;

  // input op codes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] off_code;
    logic [CODE_W-1:0] min_temp;
    logic [CODE_W-1:0] max_temp;
    logic [CODE_W-1:0] temp_step;
    logic [SYNC_W-1:0] sync_low_time;
    logic [DUR_W-1:0] pulse_high_time;
    logic [DUR_W-1:0] pulse_low_time;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FRAME
  } state_t;

  typedef enum logic [1:0] {
    ITEM_SYNC,
    ITEM_PULSE,
    ITEM_END
  } item_kind_t;

  typedef struct packed {
    logic load_cmd;
    logic load_frame;
    logic div_step;
    logic commit;
    logic emit;
    item_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic sync_left;
    logic pulses_left;
    logic frame_full;
  } dp_status_t;

endpackage

### rtl/core/pcfg_regs.sv
// configuration register file with the write port decode
// depends on pcfg_pkg
module pcfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pcfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcfg_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcfg_pkg::cfg_t                cfg
);
  import pcfg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_code <= '0;
      cfg.min_temp <= '0;
      cfg.max_temp <= CODE_W'(255);
      cfg.temp_step <= DEFAULT_STEP;
      cfg.sync_low_time <= '0;
      cfg.pulse_high_time <= '0;
      cfg.pulse_low_time <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFF_CODE:   cfg.off_code <= cfg_data[CODE_W-1:0];
        REG_MIN_TEMP:   cfg.min_temp <= cfg_data[CODE_W-1:0];
        REG_MAX_TEMP:   cfg.max_temp <= cfg_data[CODE_W-1:0];
        REG_TEMP_STEP:  cfg.temp_step <= cfg_data[CODE_W-1:0];
        REG_SYNC_LOW:   cfg.sync_low_time <= cfg_data[SYNC_W-1:0];
        REG_PULSE_HIGH: cfg.pulse_high_time <= cfg_data[DUR_W-1:0];
        REG_PULSE_LOW:  cfg.pulse_low_time <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/pcfg_ctrl.sv
// controller state machine: sequences quantizer division and frame output
// depends on pcfg_pkg
module pcfg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  pcfg_pkg::dp_status_t   status,
  output pcfg_pkg::ctrl_cmd_t    cmd
);
  import pcfg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.kind = ITEM_END;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op == OP_SEND) begin
            cmd.load_frame = 1'b1;
            state_next = S_FRAME;
          end else begin
            cmd.load_cmd = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FRAME: begin
        // one item per cycle whenever the output register can take it
        if (status.out_free) begin
          cmd.emit = 1'b1;
          priority if (status.frame_full || (!status.sync_left && !status.pulses_left)) begin
            cmd.kind = ITEM_END;
            state_next = S_IDLE;
          end else if (status.sync_left) begin
            cmd.kind = ITEM_SYNC;
          end else begin
            cmd.kind = ITEM_PULSE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/pcfg_dp.sv
// datapath: mode and code state, quantizer with bit-serial remainder,
// frame counters and output register; depends on pcfg_pkg
module pcfg_dp #(
  parameter int FRAME_ITEMS = pcfg_pkg::FRAME_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcfg_pkg::cfg_t                cfg,
  input  pcfg_pkg::ctrl_cmd_t           cmd,
  output pcfg_pkg::dp_status_t          status,
  input  logic                          heat_on,
  input  logic signed [pcfg_pkg::TEMP_W-1:0] target_temp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          level_first,
  output logic [pcfg_pkg::DUR_W-1:0]    time_first,
  output logic                          level_second,
  output logic [pcfg_pkg::DUR_W-1:0]    time_second,
  output logic                          last_item
);
  import pcfg_pkg::*;

  localparam int N_W = (FRAME_ITEMS > 2) ? $clog2(FRAME_ITEMS) : 1;
  localparam logic [N_W-1:0] N_CAP = N_W'(FRAME_ITEMS - 1);
  localparam int RND_W = TEMP_W - 3;
  localparam int TS_W = RND_W + 1;

  logic mode_on;
  logic [CODE_W-1:0] stored_code;

  // ---- quantizer front end, from the input ports ----
  logic [TEMP_W-1:0] temp_mag;
  logic [TEMP_W:0] temp_sum;
  logic [RND_W-1:0] rounded;
  logic signed [TS_W-1:0] t_round, t_lo, t_cl, min_s, max_s;
  logic [CODE_W-1:0] t8, step_eff;
  logic signed [CODE_W+1:0] num;
  logic [DIV_BITS-1:0] num_mag;

  always_comb begin
    temp_mag = target_temp[TEMP_W-1] ? TEMP_W'(-target_temp) : TEMP_W'(target_temp);
    // halves round away from zero
    temp_sum = {1'b0, temp_mag} + (TEMP_W+1)'(8);
    rounded = temp_sum[TEMP_W:4];
    t_round = target_temp[TEMP_W-1] ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
    min_s = $signed({{(TS_W-CODE_W){1'b0}}, cfg.min_temp});
    max_s = $signed({{(TS_W-CODE_W){1'b0}}, cfg.max_temp});
    t_lo = (t_round < min_s) ? min_s : t_round;
    t_cl = (t_lo > max_s) ? max_s : t_lo;
    t8 = t_cl[CODE_W-1:0];
    step_eff = (cfg.temp_step == '0) ? DEFAULT_STEP : cfg.temp_step;
    num = $signed({2'b00, t8}) - $signed({2'b00, cfg.min_temp})
        + $signed({3'b000, step_eff[CODE_W-1:1]});
    num_mag = num[CODE_W+1] ? DIV_BITS'(-num) : DIV_BITS'(num);
  end

  // ---- restoring remainder, one dividend bit per cycle ----
  logic [DIV_BITS-1:0] div_a, div_mag;
  logic div_neg;
  logic [CODE_W-1:0] div_d, div_rem, rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CODE_W:0] rem_shift;
  logic [DIV_BITS-1:0] q_mag;
  logic [CODE_W-1:0] code_next;

  always_comb begin
    rem_shift = {div_rem, div_a[DIV_BITS-1]};
    rem_next = (rem_shift >= {1'b0, div_d}) ? CODE_W'(rem_shift - {1'b0, div_d})
                                             : rem_shift[CODE_W-1:0];
    // quotient times step is the magnitude less its remainder
    q_mag = div_mag - DIV_BITS'(rem_next);
    code_next = div_neg ? (cfg.min_temp - q_mag[CODE_W-1:0])
                        : (cfg.min_temp + q_mag[CODE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      div_a <= num_mag;
      div_mag <= num_mag;
      div_neg <= num[CODE_W+1];
      div_d <= step_eff;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_a <= {div_a[DIV_BITS-2:0], 1'b0};
      div_rem <= rem_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_on <= 1'b0;
      stored_code <= '0;
    end else begin
      if (cmd.load_cmd) mode_on <= heat_on;
      if (cmd.commit) stored_code <= code_next;
    end
  end

  // ---- frame counters ----
  logic [SYNC_W-1:0] sync_rem;
  logic [CODE_W-1:0] pulses;
  logic [N_W-1:0] n_items;
  logic [DUR_W-1:0] d0, d1;
  logic [SYNC_W-1:0] sync_rem_next;
  localparam logic [SYNC_W-1:0] MAX_W = SYNC_W'(FIELD_MAX_US);
  localparam logic [SYNC_W-1:0] TWO_MAX_W = SYNC_W'(2 * 32767);

  always_comb begin
    if (sync_rem > TWO_MAX_W) begin
      d0 = FIELD_MAX_US;
      d1 = FIELD_MAX_US;
      sync_rem_next = sync_rem - TWO_MAX_W;
    end else if (sync_rem > MAX_W) begin
      d0 = FIELD_MAX_US;
      d1 = DUR_W'(sync_rem - MAX_W);
      sync_rem_next = '0;
    end else begin
      d0 = sync_rem[DUR_W-1:0];
      d1 = '0;
      sync_rem_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      sync_rem <= cfg.sync_low_time;
      pulses <= mode_on ? stored_code : cfg.off_code;
      n_items <= '0;
    end else if (cmd.emit) begin
      unique case (cmd.kind)
        ITEM_SYNC: begin
          sync_rem <= sync_rem_next;
          n_items <= n_items + N_W'(1);
        end
        ITEM_PULSE: begin
          pulses <= pulses - CODE_W'(1);
          n_items <= n_items + N_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.kind)
        ITEM_SYNC: begin
          level_first <= 1'b0;
          time_first <= d0;
          level_second <= 1'b0;
          time_second <= d1;
          last_item <= 1'b0;
        end
        ITEM_PULSE: begin
          level_first <= 1'b1;
          time_first <= cfg.pulse_high_time;
          level_second <= 1'b0;
          time_second <= cfg.pulse_low_time;
          last_item <= 1'b0;
        end
        default: begin
          level_first <= 1'b0;
          time_first <= '0;
          level_second <= 1'b0;
          time_second <= '0;
          last_item <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    status.div_last = (div_cnt == DIV_CNT_W'(DIV_BITS - 1));
    status.out_free = !out_valid || out_ready;
    status.sync_left = (sync_rem != '0);
    status.pulses_left = (pulses != '0);
    status.frame_full = (n_items == N_CAP);
  end

endmodule

### rtl/core/pulse_count_frame_generator.sv
// top level of the pulse count frame generator: register file, controller
// and datapath; depends on pcfg_pkg, pcfg_regs, pcfg_ctrl, pcfg_dp
//
// channel   direction  handshake                  payload
// in        in         in_valid / in_ready        op, heat_on, target_temp
// out       out        out_valid / out_ready      level_first, time_first,
//                                                 level_second, time_second, last_item
// cfg       in         cfg_write (no wait)        cfg_index, cfg_data
//
// a command item is accepted, then the bit-serial remainder unit steps once per
// dividend bit to snap the temperature to the step grid
// a send item gives k results (sync items, pulse pairs, end marker, k <= FRAME_ITEMS)
// at one per cycle after the accept, whenever the output register can take them
// a stalled output holds the frame counters; the next item is taken as soon
// as the end marker sits in the output register
// reset restores register defaults, mode off and code 0, and empties the output
module pulse_count_frame_generator #(
  parameter int FRAME_ITEMS = pcfg_pkg::FRAME_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pcfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcfg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic                            heat_on,
  input  logic signed [pcfg_pkg::TEMP_W-1:0] target_temp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            level_first,
  output logic [pcfg_pkg::DUR_W-1:0]      time_first,
  output logic                            level_second,
  output logic [pcfg_pkg::DUR_W-1:0]      time_second,
  output logic                            last_item
);
  import pcfg_pkg::*;

  cfg_t cfg;
  ctrl_cmd_t cmd;
  dp_status_t status;

  pcfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  pcfg_dp #(
    .FRAME_ITEMS (FRAME_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .heat_on      (heat_on),
    .target_temp  (target_temp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_first  (level_first),
    .time_first   (time_first),
    .level_second (level_second),
    .time_second  (time_second),
    .last_item    (last_item)
  );

endmodule
